[design/i2s_mcr_pkg.sv]
// Package for the I2S/TDM controller register block.
// Holds the register offsets, action codes, mode bit positions and status masks.
// No dependencies.
package i2s_mcr_pkg;

   localparam int NUM_SLOTS = 8;

   typedef enum logic [1:0] {
      ACT_READ  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_TICK  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   localparam logic [7:0] OFF_CR    = 8'h00;
   localparam logic [7:0] OFF_MRA   = 8'h04;
   localparam logic [7:0] OFF_MRB   = 8'h08;
   localparam logic [7:0] OFF_SR    = 8'h0c;
   localparam logic [7:0] OFF_IERA  = 8'h10;
   localparam logic [7:0] OFF_IDRA  = 8'h14;
   localparam logic [7:0] OFF_IMRA  = 8'h18;
   localparam logic [7:0] OFF_ISRA  = 8'h1c;
   localparam logic [7:0] OFF_IERB  = 8'h20;
   localparam logic [7:0] OFF_IDRB  = 8'h24;
   localparam logic [7:0] OFF_IMRB  = 8'h28;
   localparam logic [7:0] OFF_ISRB  = 8'h2c;
   localparam logic [7:0] OFF_RHR   = 8'h30;
   localparam logic [7:0] OFF_THR   = 8'h34;
   localparam logic [7:0] OFF_WPMR  = 8'he4;
   localparam logic [7:0] OFF_WPSR  = 8'he8;
   localparam logic [7:0] OFF_VER   = 8'hfc;

   localparam logic [31:0] PROTECT_KEY     = 32'h49325300;
   localparam logic [31:0] PROTECT_KEY_FLD = 32'hffffff00;
   localparam logic [31:0] MODE_A_WRITABLE = 32'hffffffcf;
   localparam logic [7:0]  MONO_EVEN_SLOTS = 8'h55;
   localparam logic [31:0] TX_READY_BITS   = 32'h00000003;
   localparam logic [31:0] TX_UNDER_BITS   = 32'h00000300;
   localparam logic [31:0] RX_READY_BITS   = 32'h00030000;
   localparam logic [31:0] RX_OVER_BITS    = 32'h03000000;
   localparam logic [31:0] INT_A_BITS      = 32'h03030303;

   localparam int B_RXMONO = 8;
   localparam int B_RXLOOP = 9;
   localparam int B_TXMONO = 10;
   localparam int B_TXSAME = 11;
   localparam int B_SRCCLK = 12;
   localparam int B_IWS    = 31;

   localparam logic [1:0] CFG_VERSION = 2'd0;
   localparam logic [1:0] CFG_BUSCLK  = 2'd1;
   localparam logic [1:0] CFG_GENCLK  = 2'd2;

   function automatic logic [7:0] top_onehot(input logic [7:0] m);
      logic [7:0] r;
      r = 8'd1;
      for (int i = 1; i < 8; i++) begin
         if (m[i]) begin
            r = 8'd1 << i;
         end
      end
      return r;
   endfunction

   function automatic logic is_one_bit(input logic [7:0] m);
      return (m != 8'd0) && ((m & (m - 8'd1)) == 8'd0);
   endfunction

   function automatic logic [2:0] next_slot(input logic [2:0] ch, input logic [7:0] m);
      logic [2:0] r;
      logic [2:0] n;
      r = 3'd0;
      for (int i = NUM_SLOTS; i >= 1; i--) begin
         n = 3'((int'(ch) + i) % NUM_SLOTS);
         if (m[n]) begin
            r = n;
         end
      end
      return r;
   endfunction

endpackage

[design/i2s_multichannel_controller_regs.sv]
// Top level of the I2S/TDM controller register block.
// Depends on i2s_mcr_pkg and i2s_mcr_ready.
// The result of an accepted word is registered in the output register.
// Throughput: one word per cycle; the output register is refilled whenever it is empty
// or being taken. Reset is synchronous, active high, and restores every register but the output data (out_ff).
module i2s_multichannel_controller_regs
   import i2s_mcr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // action[1:0], offset[9:2], write_data[41:10], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,  // read_data[31:0], irq_level[32], tx_dma_request[33],
                                   // rx_dma_request[34], line_word_valid[35],
                                   // line_sample[67:36], line_channel[70:68],
                                   // word_bit_cycles[82:71], zero pad
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   logic [31:0] version_ff, version_in;
   logic        busclk_ff, busclk_in, genclk_ff, genclk_in;
   logic [31:0] mode_a_ff, mode_a_in;
   logic [1:0]  mode_b_ff, mode_b_in;
   logic [31:0] mask_a_ff, mask_a_in, stat_a_ff, stat_a_in;
   logic        mask_b_ff, mask_b_in, stat_b_ff, stat_b_in;
   logic [31:0] last_rx_ff, last_rx_in;
   logic [2:0]  prot_mode_ff, prot_mode_in;
   logic [15:0] prot_stat_ff, prot_stat_in;
   logic [31:0] tx_hold_ff [8], tx_hold_in [8];
   logic [31:0] tx_last_ff [8], tx_last_in [8];
   logic [31:0] rx_hold_ff [8], rx_hold_in [8];
   logic [7:0]  tx_full_ff, tx_full_in, rx_full_ff, rx_full_in;
   logic [2:0]  tx_wslot_ff, tx_wslot_in, rx_rslot_ff, rx_rslot_in, line_slot_ff, line_slot_in;
   logic [7:0]  skip_ff, skip_in, runder_ff, runder_in;
   logic        clk_on_ff, clk_on_in, tx_on_ff, tx_on_in, rx_on_ff, rx_on_in;
   logic        valid_ff;
   logic [82:0] out_ff, out_in;

   logic [1:0]  act;
   logic [7:0]  off;
   logic [31:0] wd;
   logic        take;

   logic [2:0]  nch;
   logic [7:0]  tact_a, ract_a;
   logic        compact_a, tdm_a;
   logic [7:0]  tact_n, ract_n;
   logic        compact_n;
   logic [1:0]  tx_rdy, rx_rdy;
   logic        upd;
   logic [31:0] smask;

   assign act  = req_tdata[1:0];
   assign off  = req_tdata[9:2];
   assign wd   = req_tdata[41:10];
   assign req_tready = !valid_ff || rsp_tready;
   assign take = req_tvalid && req_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {5'd0, out_ff};

   function automatic logic [7:0] act_mask(input logic [31:0] m, input logic tx);
      logic [3:0] n;
      logic [7:0] r;
      logic [2:0] dl;
      dl = m[3:1];
      n = (m[7:6] >= 2'd2) ? ({1'b0, m[15:13]} + 4'd1) : 4'd2;
      r = 8'((9'd1 << n) - 9'd1);
      if (dl == 3'd5 || dl == 3'd7) begin
         r = 8'd1;
      end else if (tx && m[B_TXMONO]) begin
         r = r & MONO_EVEN_SLOTS;
      end
      return r;
   endfunction

   // Values derived from the mode in force at the start of the item; the ready masks use the new mode.
   always_comb begin
      tdm_a = mode_a_ff[7:6] >= 2'd2;
      nch = tdm_a ? mode_a_ff[15:13] : 3'd1;   // channel count minus one
      compact_a = (mode_a_ff[3:1] == 3'd5) || (mode_a_ff[3:1] == 3'd7);
      tact_a = act_mask(mode_a_ff, 1'b1);
      ract_a = act_mask(mode_a_ff, 1'b0);
      tact_n = act_mask(mode_a_in, 1'b1);
      ract_n = act_mask(mode_a_in, 1'b0);
      compact_n = (mode_a_in[3:1] == 3'd5) || (mode_a_in[3:1] == 3'd7);
      case (mode_a_ff[3:1])
         3'd1: smask = 32'h00ffffff;
         3'd2: smask = 32'h000fffff;
         3'd3: smask = 32'h0003ffff;
         3'd4: smask = 32'h0000ffff;
         3'd6: smask = 32'h000000ff;
         3'd7: smask = 32'h0000ffff;
         default: smask = 32'hffffffff;
      endcase
   end

   i2s_mcr_ready u_ready (
      .tx_act  (tact_n),
      .rx_act  (ract_n),
      .tx_full (tx_full_in),
      .rx_full (rx_full_in),
      .compact (compact_n),
      .tx_mono (mode_a_in[B_TXMONO]),
      .tx_rdy  (tx_rdy),
      .rx_rdy  (rx_rdy)
   );

   logic [31:0] rd;
   logic        wvalid;
   logic [31:0] sample;
   logic [2:0]  ch;
   logic        clk_act, clk_act_n;
   logic [31:0] stat_fin;
   logic [11:0] bitc;
   logic [7:0]  b;
   logic        dup;
   logic [31:0] rxs;
   logic [2:0]  chm1;
   logic [5:0]  div;
   logic [5:0]  cbase;
   logic [18:0] cprod;

   always_comb begin
      version_in = version_ff; busclk_in = busclk_ff; genclk_in = genclk_ff;
      mode_a_in = mode_a_ff; mode_b_in = mode_b_ff;
      mask_a_in = mask_a_ff; stat_a_in = stat_a_ff;
      mask_b_in = mask_b_ff; stat_b_in = stat_b_ff;
      last_rx_in = last_rx_ff; prot_mode_in = prot_mode_ff; prot_stat_in = prot_stat_ff;
      tx_hold_in = tx_hold_ff; tx_last_in = tx_last_ff; rx_hold_in = rx_hold_ff;
      tx_full_in = tx_full_ff; rx_full_in = rx_full_ff;
      tx_wslot_in = tx_wslot_ff; rx_rslot_in = rx_rslot_ff; line_slot_in = line_slot_ff;
      skip_in = skip_ff; runder_in = runder_ff;
      clk_on_in = clk_on_ff; tx_on_in = tx_on_ff; rx_on_in = rx_on_ff;
      rd = 32'd0; wvalid = 1'b0; sample = 32'd0; ch = 3'd0; upd = 1'b0;
      b = 8'd0; dup = 1'b0; rxs = 32'd0; chm1 = 3'd0;
      clk_act = clk_on_ff && (mode_a_ff[B_SRCCLK] ? genclk_ff : busclk_ff);

      if (csr_we) begin
         case (csr_index)
            CFG_VERSION: version_in = csr_wdata;
            CFG_BUSCLK:  busclk_in = csr_wdata[0];
            CFG_GENCLK:  genclk_in = csr_wdata[0];
            default: ;
         endcase
      end

      if (take) begin
         case (action_type'(act))
            ACT_READ: begin
               case (off)
                  OFF_MRA:  rd = mode_a_ff;
                  OFF_MRB:  rd = {22'd0, mode_b_ff, 8'd0};
                  OFF_SR:   rd = {27'd0, clk_act && tx_on_ff, 3'd0, clk_act && rx_on_ff};
                  OFF_IMRA: rd = mask_a_ff;
                  OFF_ISRA: begin
                     rd = stat_a_ff;
                     stat_a_in = stat_a_ff & ~(TX_UNDER_BITS | RX_OVER_BITS);
                  end
                  OFF_IMRB: rd = {31'd0, mask_b_ff};
                  OFF_ISRB: begin
                     rd = {31'd0, stat_b_ff};
                     stat_b_in = 1'b0;
                  end
                  OFF_RHR: begin
                     b = 8'd1 << rx_rslot_ff;
                     if (|(ract_a & b & rx_full_ff)) begin
                        last_rx_in = rx_hold_ff[rx_rslot_ff];
                        rx_full_in = rx_full_ff & ~b;
                        rx_rslot_in = next_slot(rx_rslot_ff, ract_a);
                        upd = 1'b1;
                     end
                     rd = last_rx_in;
                  end
                  OFF_WPMR: rd = {29'd0, prot_mode_ff};
                  OFF_WPSR: begin
                     rd = {16'd0, prot_stat_ff};
                     prot_stat_in = 16'd0;
                  end
                  OFF_VER:  rd = version_ff;
                  default:  rd = 32'd0;
               endcase
            end
            ACT_WRITE: begin
               case (off)
                  OFF_CR: begin
                     if (prot_mode_ff[2]) begin
                        prot_stat_in = {off, 8'h01}; stat_b_in = 1'b1;
                     end else if (wd[7]) begin
                        mode_a_in = 32'd0; mode_b_in = 2'd0; mask_a_in = 32'd0;
                        stat_a_in = TX_READY_BITS; mask_b_in = 1'b0; stat_b_in = 1'b0;
                        last_rx_in = 32'd0;
                        for (int i = 0; i < 8; i++) begin
                           tx_hold_in[i] = 32'd0; tx_last_in[i] = 32'd0;
                           rx_hold_in[i] = 32'd0;
                        end
                        tx_full_in = 8'd0; rx_full_in = 8'd0;
                        tx_wslot_in = 3'd0; rx_rslot_in = 3'd0; line_slot_in = 3'd0;
                        skip_in = 8'd0; runder_in = 8'd0;
                        clk_on_in = 1'b0; tx_on_in = 1'b0; rx_on_in = 1'b0;
                        prot_stat_in = 16'd0;
                     end else begin
                        if (wd[3]) clk_on_in = 1'b0;
                        else if (wd[2]) clk_on_in = 1'b1;
                        if (wd[5]) begin
                           tx_full_in = 8'd0; skip_in = 8'd0; runder_in = 8'd0;
                           tx_on_in = 1'b0;
                        end else if (wd[4]) begin
                           if (!tx_on_ff) tx_wslot_in = 3'd0;
                           tx_on_in = 1'b1;
                        end
                        if (wd[1]) begin
                           for (int i = 0; i < 8; i++) begin
                              if (ract_a[i]) rx_hold_in[i] = 32'd0;
                           end
                           rx_full_in = rx_full_ff | ract_a;
                           rx_on_in = 1'b0;
                        end else if (wd[0]) begin
                           rx_on_in = 1'b1; rx_rslot_in = 3'd0;
                        end
                        upd = 1'b1;
                     end
                  end
                  OFF_MRA, OFF_MRB: begin
                     if (prot_mode_ff[0]) begin
                        prot_stat_in = {off, 8'h01}; stat_b_in = 1'b1;
                     end else if (off == OFF_MRA) begin
                        mode_a_in = wd & MODE_A_WRITABLE;
                        tx_wslot_in = 3'd0; rx_rslot_in = 3'd0; line_slot_in = 3'd0;
                        upd = 1'b1;
                     end else begin
                        mode_b_in = wd[9:8];
                     end
                  end
                  OFF_IERA, OFF_IDRA, OFF_IERB, OFF_IDRB: begin
                     if (prot_mode_ff[1]) begin
                        prot_stat_in = {off, 8'h01}; stat_b_in = 1'b1;
                     end else if (off == OFF_IERA) begin
                        mask_a_in = mask_a_ff | (wd & INT_A_BITS);
                     end else if (off == OFF_IDRA) begin
                        mask_a_in = mask_a_ff & ~(wd & INT_A_BITS);
                     end else if (off == OFF_IERB) begin
                        mask_b_in = mask_b_ff | wd[0];
                     end else begin
                        mask_b_in = mask_b_ff & ~wd[0];
                     end
                  end
                  OFF_THR: begin
                     b = 8'd1 << tx_wslot_ff;
                     if (|(tact_a & b) && !(|(tx_full_ff & b))) begin
                        if (|(skip_ff & b)) begin
                           skip_in = skip_ff & ~b;
                        end else begin
                           tx_hold_in[tx_wslot_ff] = wd & smask;
                           tx_full_in = tx_full_ff | b;
                        end
                        tx_wslot_in = next_slot(tx_wslot_ff, tact_a);
                        upd = 1'b1;
                     end
                  end
                  OFF_WPMR: begin
                     if ((wd & PROTECT_KEY_FLD) == PROTECT_KEY) prot_mode_in = wd[2:0];
                  end
                  default: ;
               endcase
            end
            ACT_TICK: begin
               if (clk_act && (tx_on_ff || rx_on_ff)) begin
                  wvalid = 1'b1;
                  ch = (line_slot_ff > nch) ? 3'd0 : line_slot_ff;
                  chm1 = ch - 3'd1;
                  b = 8'd1 << ch;
                  dup = mode_a_ff[B_TXMONO] || compact_a;
                  if (tx_on_ff && |(tact_a & b)) begin
                     if (|(tx_full_ff & b)) begin
                        sample = tx_hold_ff[ch];
                        tx_last_in[ch] = sample;
                        tx_full_in = tx_full_ff & ~b;
                     end else begin
                        if (ch[0]) stat_a_in[9] = 1'b1;
                        else stat_a_in[8] = 1'b1;
                        skip_in = skip_ff | b;
                        if (dup && !ch[0] && ch < nch) runder_in = runder_ff | (b << 1);
                        if (mode_a_ff[B_TXSAME]) sample = tx_last_ff[ch];
                     end
                     upd = 1'b1;
                  end else if (tx_on_ff && dup && ch[0]) begin
                     if (|(runder_ff & b)) begin
                        stat_a_in[9] = 1'b1;
                        runder_in = runder_ff & ~b;
                     end
                     if (mode_a_ff[B_TXMONO]) sample = tx_last_ff[chm1];
                  end
                  if (rx_on_ff) begin
                     if (!mode_a_ff[B_RXLOOP]) rxs = 32'd0;
                     else if (mode_a_ff[B_RXMONO] && ch[0]) rxs = rx_hold_ff[chm1];
                     else rxs = sample;
                     if (|(ract_a & b)) begin
                        if (|(rx_full_ff & b)) begin
                           if (ch[0]) stat_a_in[25] = 1'b1;
                           else stat_a_in[24] = 1'b1;
                        end
                        rx_hold_in[ch] = rxs;
                        rx_full_in = rx_full_ff | b;
                        upd = 1'b1;
                     end
                  end
                  line_slot_in = (ch >= nch) ? 3'd0 : ch + 3'd1;
               end
            end
            default: ;
         endcase
      end

      stat_fin = stat_a_in;
      if (upd) begin
         stat_fin = (stat_a_in & ~(TX_READY_BITS | RX_READY_BITS))
                  | {14'd0, rx_rdy, 14'd0, tx_rdy};
      end
      stat_a_in = stat_fin;

      clk_act_n = clk_on_in && (mode_a_in[B_SRCCLK] ? genclk_ff : busclk_ff) && busclk_ff;
      div = mode_a_in[29:24];
      if (mode_a_in[7:6] >= 2'd2) begin
         cbase = 6'd32;
      end else begin
         case (mode_a_in[3:1])
            3'd1, 3'd2, 3'd3: cbase = mode_a_in[B_IWS] ? 6'd24 : 6'd32;
            3'd4, 3'd5: cbase = 6'd16;
            3'd6, 3'd7: cbase = 6'd8;
            default: cbase = 6'd32;
         endcase
      end
      cprod = {13'd0, cbase} * {12'd0, div, 1'b0};
      bitc = (div != 6'd0) ? cprod[11:0] : {6'd0, cbase};

      out_in = {bitc, ch, sample, wvalid,
                clk_act_n && rx_on_in && |(stat_a_in & RX_READY_BITS),
                clk_act_n && tx_on_in && |(stat_a_in & TX_READY_BITS),
                ((|(stat_a_in & mask_a_in)) || (stat_b_in && mask_b_in)) && busclk_ff,
                rd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= 32'h100; busclk_ff <= 1'b1; genclk_ff <= 1'b1;
         mode_a_ff <= 32'd0; mode_b_ff <= 2'd0; mask_a_ff <= 32'd0;
         stat_a_ff <= TX_READY_BITS; mask_b_ff <= 1'b0; stat_b_ff <= 1'b0;
         last_rx_ff <= 32'd0; prot_mode_ff <= 3'd0; prot_stat_ff <= 16'd0;
         for (int i = 0; i < 8; i++) begin
            tx_hold_ff[i] <= 32'd0; tx_last_ff[i] <= 32'd0; rx_hold_ff[i] <= 32'd0;
         end
         tx_full_ff <= 8'd0; rx_full_ff <= 8'd0;
         tx_wslot_ff <= 3'd0; rx_rslot_ff <= 3'd0; line_slot_ff <= 3'd0;
         skip_ff <= 8'd0; runder_ff <= 8'd0;
         clk_on_ff <= 1'b0; tx_on_ff <= 1'b0; rx_on_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         version_ff <= version_in; busclk_ff <= busclk_in; genclk_ff <= genclk_in;
         mode_a_ff <= mode_a_in; mode_b_ff <= mode_b_in; mask_a_ff <= mask_a_in;
         stat_a_ff <= stat_a_in; mask_b_ff <= mask_b_in; stat_b_ff <= stat_b_in;
         last_rx_ff <= last_rx_in; prot_mode_ff <= prot_mode_in; prot_stat_ff <= prot_stat_in;
         tx_hold_ff <= tx_hold_in; tx_last_ff <= tx_last_in; rx_hold_ff <= rx_hold_in;
         tx_full_ff <= tx_full_in; rx_full_ff <= rx_full_in;
         tx_wslot_ff <= tx_wslot_in; rx_rslot_ff <= rx_rslot_in; line_slot_ff <= line_slot_in;
         skip_ff <= skip_in; runder_ff <= runder_in;
         clk_on_ff <= clk_on_in; tx_on_ff <= tx_on_in; rx_on_ff <= rx_on_in;
         if (take) valid_ff <= 1'b1;
         else if (rsp_tready) valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) out_ff <= out_in;
   end
endmodule

[design/i2s_mcr_ready.sv]
// Ready-bit computation for the transmit and receive holding slots.
// Depends on i2s_mcr_pkg.
module i2s_mcr_ready
   import i2s_mcr_pkg::*;
(
   input  logic [7:0] tx_act,
   input  logic [7:0] rx_act,
   input  logic [7:0] tx_full,
   input  logic [7:0] rx_full,
   input  logic       compact,
   input  logic       tx_mono,
   output logic [1:0] tx_rdy,
   output logic [1:0] rx_rdy
);
   logic [7:0] tlb;
   logic [7:0] rlb;

   always_comb begin
      tlb = top_onehot(tx_act);
      rlb = top_onehot(rx_act);
      tx_rdy = 2'b00;
      rx_rdy = 2'b00;
      if (is_one_bit(tx_act) || compact || tx_mono) begin
         tx_rdy[0] = |(tx_act & ~tx_full);
      end else begin
         tx_rdy[0] = |((tx_act & ~tlb) & ~tx_full);
         tx_rdy[1] = ~|(tx_full & tlb);
      end
      if (is_one_bit(rx_act) || compact) begin
         rx_rdy[0] = |(rx_act & rx_full);
      end else begin
         rx_rdy[0] = |((rx_act & ~rlb) & rx_full);
         rx_rdy[1] = |(rx_full & rlb);
      end
   end
endmodule

[sim/tb_top.sv]
// Self-checking testbench for the I2S/TDM controller register block.
// Drives bus accesses and word ticks, predicts every response word and compares field by field.
// Depends on i2s_mcr_pkg and i2s_multichannel_controller_regs.
`timescale 1ns / 100ps

module tb_top;
   import i2s_mcr_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int ITEM_TARGET = 1800;

   typedef struct {
      logic [31:0] read_data;
      logic        irq_level;
      logic        tx_req;
      logic        rx_req;
      logic        word_valid;
      logic [31:0] sample;
      logic [2:0]  channel;
      logic [11:0] bit_cycles;
   } rsp_word_type;

   typedef struct {
      action_type  act;
      logic [7:0]  off;
      logic [31:0] wdata;
      bit          typed;
      logic [31:0] rdata;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CFG_VERSION;
   logic [31:0] csr_wdata = '0;

   rsp_word_type rsp_due_q[$];
   int        errors = 0;
   int        cycles = 0;
   int        items = 0;
   bit        quiet = 1'b0;
   bit        hold_req = 1'b0;

   // Predicted register block state.
   logic [31:0] cfg_version;
   logic        cfg_busclk, cfg_genclk;
   logic [31:0] p_mode_a, p_mask_a, p_stat_a, p_last_rx;
   logic [1:0]  p_mode_b;
   logic        p_mask_b, p_stat_b;
   logic [2:0]  p_prot;
   logic [15:0] p_prot_st;
   logic [31:0] p_tx_hold[8], p_tx_last[8], p_rx_hold[8];
   logic [7:0]  p_tx_full, p_rx_full, p_skip, p_right_ur;
   logic [2:0]  p_tx_slot, p_rx_slot, p_line_slot;
   logic        p_clk_on, p_tx_on, p_rx_on;

   i2s_multichannel_controller_regs u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   function automatic int data_len();
      return int'(p_mode_a[3:1]);
   endfunction

   function automatic bit fmt_tdm();
      return p_mode_a[7:6] >= 2'd2;
   endfunction

   function automatic bit fmt_compact();
      return data_len() == 5 || data_len() == 7;
   endfunction

   function automatic int slot_count();
      int n;
      n = fmt_tdm() ? int'(p_mode_a[15:13]) + 1 : 2;
      return (n > NUM_SLOTS) ? NUM_SLOTS : n;
   endfunction

   function automatic logic [7:0] slot_mask(bit tx);
      logic [8:0] m;
      m = (9'd1 << slot_count()) - 9'd1;
      if (fmt_compact()) return 8'd1;
      if (tx && p_mode_a[B_TXMONO]) m[7:0] = m[7:0] & MONO_EVEN_SLOTS;
      return m[7:0];
   endfunction

   function automatic logic [31:0] width_mask();
      case (data_len())
         1: return 32'h00ffffff;
         2: return 32'h000fffff;
         3: return 32'h0003ffff;
         4, 7: return 32'h0000ffff;
         6: return 32'h000000ff;
         default: return 32'hffffffff;
      endcase
   endfunction

   function automatic logic [7:0] highest_slot(logic [7:0] m);
      logic [7:0] r;
      r = 8'd1;
      for (int i = 0; i < 8; i++) if (m[i]) r = 8'd1 << i;
      return r;
   endfunction

   function automatic bit single_slot(logic [7:0] m);
      return $countones(m) == 1;
   endfunction

   function automatic logic [2:0] following_slot(int ch, logic [7:0] m);
      int n;
      for (int i = 1; i <= NUM_SLOTS; i++) begin
         n = (ch + i) % NUM_SLOTS;
         if (m[n]) return 3'(n);
      end
      return 3'd0;
   endfunction

   function automatic void refresh_ready();
      logic [7:0] ta, ra, lb;
      ta = slot_mask(1'b1);
      ra = slot_mask(1'b0);
      p_stat_a = p_stat_a & ~(TX_READY_BITS | RX_READY_BITS);
      if (single_slot(ta) || fmt_compact() || p_mode_a[B_TXMONO]) begin
         if ((ta & ~p_tx_full) != 0) p_stat_a[0] = 1'b1;
      end else begin
         lb = highest_slot(ta);
         if ((ta & ~lb & ~p_tx_full) != 0) p_stat_a[0] = 1'b1;
         if ((p_tx_full & lb) == 0) p_stat_a[1] = 1'b1;
      end
      if (single_slot(ra) || fmt_compact()) begin
         if ((ra & p_rx_full) != 0) p_stat_a[16] = 1'b1;
      end else begin
         lb = highest_slot(ra);
         if ((ra & ~lb & p_rx_full) != 0) p_stat_a[16] = 1'b1;
         if ((p_rx_full & lb) != 0) p_stat_a[17] = 1'b1;
      end
   endfunction

   function automatic bit clk_running();
      return p_clk_on && (p_mode_a[B_SRCCLK] ? cfg_genclk : cfg_busclk);
   endfunction

   function automatic logic [11:0] cycles_per_word();
      logic [31:0] c;
      logic [31:0] div;
      div = {26'd0, p_mode_a[29:24]};
      if (fmt_tdm()) c = 32;
      else case (data_len())
         1, 2, 3: c = p_mode_a[B_IWS] ? 32'd24 : 32'd32;
         4, 5: c = 16;
         6, 7: c = 8;
         default: c = 32;
      endcase
      if (div != 0) c = c * 2 * div;
      return c[11:0];
   endfunction

   function automatic void clear_state(bit hard);
      p_mode_a = '0; p_mode_b = '0; p_mask_a = '0; p_stat_a = TX_READY_BITS;
      p_mask_b = 1'b0; p_stat_b = 1'b0; p_last_rx = '0;
      for (int i = 0; i < 8; i++) begin
         p_tx_hold[i] = '0; p_tx_last[i] = '0; p_rx_hold[i] = '0;
      end
      p_tx_full = '0; p_rx_full = '0; p_tx_slot = '0; p_rx_slot = '0; p_line_slot = '0;
      p_skip = '0; p_right_ur = '0;
      p_clk_on = 1'b0; p_tx_on = 1'b0; p_rx_on = 1'b0;
      p_prot_st = '0;
      if (hard) p_prot = '0;
   endfunction

   function automatic void flag_violation(logic [7:0] off);
      p_prot_st = {off, 8'd1};
      p_stat_b = 1'b1;
   endfunction

   function automatic void control_write(logic [31:0] v);
      logic [7:0] ra;
      v = v & 32'hbf;
      if (v[7]) begin
         clear_state(1'b0);
         return;
      end
      if (v[3]) p_clk_on = 1'b0;
      else if (v[2]) p_clk_on = 1'b1;
      if (v[5]) begin
         p_tx_full = '0; p_skip = '0; p_right_ur = '0; p_tx_on = 1'b0;
      end else if (v[4]) begin
         if (!p_tx_on) p_tx_slot = '0;
         p_tx_on = 1'b1;
      end
      ra = slot_mask(1'b0);
      if (v[1]) begin
         for (int i = 0; i < 8; i++) if (ra[i]) begin
            p_rx_hold[i] = '0;
            p_rx_full[i] = 1'b1;
         end
         p_rx_on = 1'b0;
      end else if (v[0]) begin
         p_rx_on = 1'b1;
         p_rx_slot = '0;
      end
      refresh_ready();
   endfunction

   function automatic void sample_write(logic [31:0] v);
      logic [7:0] ta;
      int ch;
      ta = slot_mask(1'b1);
      ch = int'(p_tx_slot);
      if (!ta[ch] || p_tx_full[ch]) return;
      if (p_skip[ch]) p_skip[ch] = 1'b0;
      else begin
         p_tx_hold[ch] = v & width_mask();
         p_tx_full[ch] = 1'b1;
      end
      p_tx_slot = following_slot(ch, ta);
      refresh_ready();
   endfunction

   function automatic logic [31:0] reg_read(logic [7:0] off);
      logic [31:0] v;
      logic [7:0] ra;
      int ch;
      case (off)
         OFF_MRA: return p_mode_a;
         OFF_MRB: return {22'd0, p_mode_b, 8'd0};
         OFF_SR: return {27'd0, clk_running() && p_tx_on, 3'd0, clk_running() && p_rx_on};
         OFF_IMRA: return p_mask_a;
         OFF_ISRA: begin
            v = p_stat_a;
            p_stat_a = p_stat_a & ~(TX_UNDER_BITS | RX_OVER_BITS);
            return v;
         end
         OFF_IMRB: return {31'd0, p_mask_b};
         OFF_ISRB: begin
            v = {31'd0, p_stat_b};
            p_stat_b = 1'b0;
            return v;
         end
         OFF_RHR: begin
            ra = slot_mask(1'b0);
            ch = int'(p_rx_slot);
            if (ra[ch] && p_rx_full[ch]) begin
               p_last_rx = p_rx_hold[ch];
               p_rx_full[ch] = 1'b0;
               p_rx_slot = following_slot(ch, ra);
               refresh_ready();
            end
            return p_last_rx;
         end
         OFF_WPMR: return {29'd0, p_prot};
         OFF_WPSR: begin
            v = {16'd0, p_prot_st};
            p_prot_st = '0;
            return v;
         end
         OFF_VER: return cfg_version;
         default: return '0;
      endcase
   endfunction

   function automatic void reg_write(logic [7:0] off, logic [31:0] v);
      case (off)
         OFF_CR: if (p_prot[2]) flag_violation(off); else control_write(v);
         OFF_MRA: if (p_prot[0]) flag_violation(off); else begin
            p_mode_a = v & MODE_A_WRITABLE;
            p_tx_slot = '0; p_rx_slot = '0; p_line_slot = '0;
            refresh_ready();
         end
         OFF_MRB: if (p_prot[0]) flag_violation(off); else p_mode_b = v[9:8];
         OFF_IERA: if (p_prot[1]) flag_violation(off); else p_mask_a = p_mask_a | (v & INT_A_BITS);
         OFF_IDRA: if (p_prot[1]) flag_violation(off); else p_mask_a = p_mask_a & ~(v & INT_A_BITS);
         OFF_IERB: if (p_prot[1]) flag_violation(off); else p_mask_b = p_mask_b | v[0];
         OFF_IDRB: if (p_prot[1]) flag_violation(off); else p_mask_b = p_mask_b & ~v[0];
         OFF_THR: sample_write(v);
         OFF_WPMR: if ((v & PROTECT_KEY_FLD) == PROTECT_KEY) p_prot = v[2:0];
         default: ;
      endcase
   endfunction

   function automatic bit word_time(output logic [31:0] s, output logic [2:0] c);
      int chans, ch;
      logic [7:0] ta, ra, b;
      logic [31:0] rxs;
      bit dup;
      s = '0;
      c = '0;
      if (!clk_running() || (!p_tx_on && !p_rx_on)) return 1'b0;
      chans = slot_count();
      ch = int'(p_line_slot) % chans;
      b = 8'd1 << ch;
      ta = slot_mask(1'b1);
      dup = p_mode_a[B_TXMONO] || fmt_compact();
      if (p_tx_on && (ta & b) != 0) begin
         if ((p_tx_full & b) != 0) begin
            s = p_tx_hold[ch];
            p_tx_last[ch] = s;
            p_tx_full = p_tx_full & ~b;
         end else begin
            p_stat_a[(ch % 2) ? 9 : 8] = 1'b1;
            p_skip = p_skip | b;
            if (dup && (ch % 2) == 0 && ch + 1 < chans) p_right_ur = p_right_ur | (b << 1);
            if (p_mode_a[B_TXSAME]) s = p_tx_last[ch];
         end
         refresh_ready();
      end else if (p_tx_on && dup && (ch % 2) == 1) begin
         if ((p_right_ur & b) != 0) begin
            p_stat_a[9] = 1'b1;
            p_right_ur = p_right_ur & ~b;
         end
         if (p_mode_a[B_TXMONO]) s = p_tx_last[ch - 1];
      end
      if (p_rx_on) begin
         rxs = s;
         if (!p_mode_a[B_RXLOOP]) rxs = '0;
         else if (p_mode_a[B_RXMONO] && (ch % 2) == 1) rxs = p_rx_hold[ch - 1];
         ra = slot_mask(1'b0);
         if ((ra & b) != 0) begin
            if ((p_rx_full & b) != 0) p_stat_a[(ch % 2) ? 25 : 24] = 1'b1;
            p_rx_hold[ch] = rxs;
            p_rx_full = p_rx_full | b;
            refresh_ready();
         end
      end
      p_line_slot = 3'((ch + 1) % chans);
      c = 3'(ch);
      return 1'b1;
   endfunction

   function automatic rsp_word_type predict_response(action_type a, logic [7:0] off,
                                                     logic [31:0] wd);
      rsp_word_type r;
      bit running;
      r.read_data = '0;
      r.word_valid = 1'b0;
      r.sample = '0;
      r.channel = '0;
      case (a)
         ACT_READ: r.read_data = reg_read(off);
         ACT_WRITE: reg_write(off, wd);
         ACT_TICK: r.word_valid = word_time(r.sample, r.channel);
         default: ;
      endcase
      running = clk_running() && cfg_busclk;
      r.irq_level = (((p_stat_a & p_mask_a) != 0) || (p_stat_b && p_mask_b)) && cfg_busclk;
      r.tx_req = running && p_tx_on && ((p_stat_a & TX_READY_BITS) != 0);
      r.rx_req = running && p_rx_on && ((p_stat_a & RX_READY_BITS) != 0);
      r.bit_cycles = cycles_per_word();
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch in %s at cycle %0d: got %h, wanted %h", field, cycles, got, want);
      errors++;
   endtask

   // A word is taken at the rising edge after a falling edge that sees valid and ready high.
   always @(negedge clock) begin
      rsp_word_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rsp_due_q.size() == 0) begin
            report_mismatch("unexpected word", rsp_tdata[31:0], '0);
         end else begin
            w = rsp_due_q.pop_front();
            if (rsp_tdata[31:0] !== w.read_data)
               report_mismatch("read_data", rsp_tdata[31:0], w.read_data);
            if (rsp_tdata[32] !== w.irq_level)
               report_mismatch("irq_level", rsp_tdata[32], w.irq_level);
            if (rsp_tdata[33] !== w.tx_req)
               report_mismatch("tx_dma_request", rsp_tdata[33], w.tx_req);
            if (rsp_tdata[34] !== w.rx_req)
               report_mismatch("rx_dma_request", rsp_tdata[34], w.rx_req);
            if (rsp_tdata[35] !== w.word_valid)
               report_mismatch("line_word_valid", rsp_tdata[35], w.word_valid);
            if (rsp_tdata[67:36] !== w.sample)
               report_mismatch("line_sample", rsp_tdata[67:36], w.sample);
            if (rsp_tdata[70:68] !== w.channel)
               report_mismatch("line_channel", rsp_tdata[70:68], w.channel);
            if (rsp_tdata[82:71] !== w.bit_cycles)
               report_mismatch("word_bit_cycles", rsp_tdata[82:71], w.bit_cycles);
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
         end
         rsp_tready <= quiet || ($urandom_range(99) >= 30);
      end
   end

   task automatic send_word(action_type a, logic [7:0] off, logic [31:0] wd,
                            bit typed = 1'b0, logic [31:0] typed_rd = '0);
      rsp_word_type r;
      if (!quiet && $urandom_range(99) < 30) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, wd, off, a};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      r = predict_response(a, off, wd);
      if (typed) r.read_data = typed_rd;
      rsp_due_q.push_back(r);
      items++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (rsp_due_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CFG_VERSION: cfg_version = v;
         CFG_BUSCLK: cfg_busclk = v[0];
         default: cfg_genclk = v[0];
      endcase
      @(posedge clock);
   endtask

   function automatic logic [31:0] random_mode();
      logic [31:0] v;
      v = $urandom;
      v[29:24] = ($urandom_range(3) == 0) ? 6'($urandom) : 6'd0;
      v[12] = ($urandom_range(3) == 0);
      return v;
   endfunction

   task automatic random_session();
      int n, pick;
      send_word(ACT_WRITE, OFF_MRA, random_mode());
      send_word(ACT_WRITE, OFF_IERA, $urandom);
      send_word(ACT_WRITE, OFF_IERB, $urandom);
      send_word(ACT_WRITE, OFF_CR, 32'h15);
      n = $urandom_range(20, 80);
      repeat (n) begin
         pick = $urandom_range(99);
         if (pick < 35) send_word(ACT_WRITE, OFF_THR, $urandom);
         else if (pick < 62) send_word(ACT_TICK, 8'($urandom), $urandom);
         else if (pick < 74) send_word(ACT_READ, OFF_RHR, $urandom);
         else if (pick < 82) send_word(ACT_READ, ($urandom_range(1) ? OFF_ISRA : OFF_ISRB), '0);
         else if (pick < 85) send_word(ACT_READ, ($urandom_range(1) ? OFF_SR : OFF_WPSR), '0);
         else if (pick < 88) begin
            send_word(ACT_WRITE, OFF_WPMR, PROTECT_KEY | 32'($urandom_range(7)));
            send_word(ACT_WRITE, 8'($urandom_range(9) * 4), $urandom);
            send_word(ACT_WRITE, OFF_WPMR, PROTECT_KEY);
         end else if (pick < 92) begin
            case ($urandom_range(5))
               0: send_word(ACT_WRITE, OFF_CR, 32'h80);
               1: send_word(ACT_WRITE, OFF_CR, 32'h22);
               2: send_word(ACT_WRITE, OFF_CR, 32'h08);
               3: send_word(ACT_WRITE, OFF_CR, 32'h15);
               4: send_word(ACT_WRITE, OFF_IDRA, $urandom);
               default: send_word(ACT_WRITE, OFF_CR, $urandom);
            endcase
         end else if (pick < 95) send_word(ACT_READ, 8'($urandom_range(63) * 4), '0);
         else send_word(action_type'($urandom_range(3)), 8'($urandom), $urandom);
      end
   endtask

   stim_row_type directed[] = '{
      '{ACT_READ,  OFF_VER,  32'h0,        1'b1, 32'h00000100},
      '{ACT_READ,  OFF_ISRA, 32'h0,        1'b1, 32'h00000003},
      '{ACT_READ,  8'h40,    32'h0,        1'b1, 32'h00000000},
      '{ACT_READ,  OFF_SR,   32'h0,        1'b1, 32'h00000000},
      '{ACT_WRITE, OFF_MRA,  32'hffffffff, 1'b0, 32'h0},
      '{ACT_READ,  OFF_MRA,  32'h0,        1'b1, 32'hffffffcf},
      '{ACT_WRITE, OFF_MRA,  32'h00000000, 1'b0, 32'h0},
      '{ACT_WRITE, OFF_IERA, 32'hffffffff, 1'b0, 32'h0},
      '{ACT_READ,  OFF_IMRA, 32'h0,        1'b1, 32'h03030303},
      '{ACT_WRITE, OFF_CR,   32'h00000015, 1'b0, 32'h0},
      '{ACT_WRITE, OFF_THR,  32'hffffffff, 1'b0, 32'h0},
      '{ACT_TICK,  8'hff,    32'h0,        1'b0, 32'h0},
      '{ACT_TICK,  8'h00,    32'h0,        1'b0, 32'h0},
      '{ACT_READ,  OFF_ISRA, 32'h0,        1'b0, 32'h0},
      '{ACT_READ,  OFF_RHR,  32'h0,        1'b0, 32'h0},
      '{ACT_NONE,  8'hff,    32'hffffffff, 1'b1, 32'h00000000},
      '{ACT_WRITE, OFF_WPMR, 32'h12345607, 1'b0, 32'h0},
      '{ACT_WRITE, OFF_WPMR, 32'h49325307, 1'b0, 32'h0},
      '{ACT_WRITE, OFF_CR,   32'h00000015, 1'b0, 32'h0},
      '{ACT_READ,  OFF_WPSR, 32'h0,        1'b1, 32'h00000001},
      '{ACT_READ,  OFF_ISRB, 32'h0,        1'b1, 32'h00000001},
      '{ACT_WRITE, OFF_WPMR, 32'h49325300, 1'b0, 32'h0},
      '{ACT_WRITE, OFF_CR,   32'h00000080, 1'b0, 32'h0},
      '{ACT_READ,  OFF_ISRA, 32'h0,        1'b1, 32'h00000003},
      '{ACT_WRITE, OFF_IERB, 32'h00000001, 1'b0, 32'h0}
   };

   initial begin
      logic [31:0] settings[5][3];
      cfg_version = 32'h100;
      cfg_busclk = 1'b1;
      cfg_genclk = 1'b1;
      clear_state(1'b1);
      settings = '{'{32'h100, 1, 1}, '{$urandom, 1, 0}, '{32'hffffffff, 0, 1},
                   '{32'h0, 0, 0}, '{$urandom, 1, 1}};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i])
         send_word(directed[i].act, directed[i].off, directed[i].wdata,
                   directed[i].typed, directed[i].rdata);
      drain();
      for (int ph = 0; ph < 5; ph++) begin
         csr_write(CFG_VERSION, settings[ph][0]);
         csr_write(CFG_BUSCLK, settings[ph][1]);
         csr_write(CFG_GENCLK, settings[ph][2]);
         quiet = (ph == 2);
         if (ph == 1) hold_req = 1'b1;
         while (items < (ph + 1) * ITEM_TARGET / 5) begin
            random_session();
            if ($urandom_range(9) == 0) drain();
         end
         drain();
      end
      repeat (10) @(posedge clock);
      if (errors == 0 && rsp_due_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

[files.f]
design/i2s_mcr_pkg.sv
design/i2s_mcr_ready.sv
design/i2s_multichannel_controller_regs.sv
sim/tb_top.sv
